>>> design/ccov_pkg.sv
// Shared constants, types and lookup functions for the colour covariance accumulator.
`timescale 1ns / 1ps

package ccov_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int IN_BITS         = 16;
    localparam int OUT_BITS        = 32;
    localparam int PROD_BITS       = 2 * SAMPLE_BITS;
    localparam int SUM_BITS        = 2 * SAMPLE_BITS + MAX_PIXELS_LOG2;
    localparam int CNT_BITS        = MAX_PIXELS_LOG2 + 1;
    localparam int STEP_BITS       = $clog2(SUM_BITS);
    localparam int NUM_PAIRS       = 6;
    localparam int PAIR_BITS       = 3;
    localparam int IDX_BITS        = 2;
    localparam int NUM_ENTRIES     = 9;
    localparam int ENTRY_BITS      = $clog2(NUM_ENTRIES);

    typedef enum logic [2:0] {
        S_ACCUM,
        S_FLUSH,
        S_LOAD,
        S_DIV,
        S_CAPT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 accum;
        logic                 load;
        logic                 step;
        logic                 capture;
        logic                 clear;
        logic [PAIR_BITS-1:0] sel;
        logic [IDX_BITS-1:0]  row;
        logic [IDX_BITS-1:0]  col;
        logic                 last;
    } t_cmd;

    function automatic logic [IDX_BITS-1:0] entry_row(input logic [ENTRY_BITS-1:0] k);
        logic [IDX_BITS-1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_BITS-1:0] entry_col(input logic [ENTRY_BITS-1:0] k);
        logic [IDX_BITS-1:0] c;
        case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    // Index of the stored sum for a matrix position; mirrored entries share a sum.
    function automatic logic [PAIR_BITS-1:0] pair_index(input logic [IDX_BITS-1:0] r,
                                                         input logic [IDX_BITS-1:0] c);
        logic [PAIR_BITS-1:0] p;
        case ({r, c})
            4'b0000:          p = 3'd0;
            4'b0001, 4'b0100: p = 3'd1;
            4'b0010, 4'b1000: p = 3'd2;
            4'b0101:          p = 3'd3;
            4'b0110, 4'b1001: p = 3'd4;
            default:          p = 3'd5;
        endcase
        return p;
    endfunction

endpackage

>>> design/color_covariance_accumulator.sv
// Top level of the 3x3 colour covariance accumulator.
`timescale 1ns / 1ps

// Pixels are taken one per cycle while accumulating; each has its six channel
// products registered and added to 52-bit sums in the following cycle, and the
// count stops at 2^20 pixels. A transaction with last_pixel set starts the
// read-out: the input stalls, and the nine matrix entries (row-major, mirrored
// entries repeated) are produced by a shared one-bit-per-cycle divider. A flush
// state comes first. Each entry then passes through a load, 52 divide steps, a
// capture and an output state, which an output stall holds. After the ninth
// transaction completes, the sums and count clear, and pixels are accepted
// again from the next cycle.
module color_covariance_accumulator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [ccov_pkg::IN_BITS-1:0]  i_chan0,
    input  logic signed [ccov_pkg::IN_BITS-1:0]  i_chan1,
    input  logic signed [ccov_pkg::IN_BITS-1:0]  i_chan2,
    input  logic                                 i_last_pixel,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [ccov_pkg::IDX_BITS-1:0]        o_row,
    output logic [ccov_pkg::IDX_BITS-1:0]        o_col,
    output logic signed [ccov_pkg::OUT_BITS-1:0] o_cov_value,
    output logic                                 o_last_entry
);

    ccov_pkg::t_cmd w_cmd;

    ccov_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_pixel (i_last_pixel),
        .i_stall      (i_stall),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_cmd        (w_cmd)
    );

    ccov_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_chan0      (i_chan0),
        .i_chan1      (i_chan1),
        .i_chan2      (i_chan2),
        .o_row        (o_row),
        .o_col        (o_col),
        .o_cov_value  (o_cov_value),
        .o_last_entry (o_last_entry)
    );

endmodule

>>> design/ccov_ctrl.sv
// Sequencer: accumulation, per-entry division and result hand-off.
`timescale 1ns / 1ps

module ccov_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last_pixel,
    input  logic            i_stall,
    output logic            o_stall,
    output logic            o_valid,
    output ccov_pkg::t_cmd  o_cmd
);

    ccov_pkg::t_state r_state, n_state;
    logic [ccov_pkg::STEP_BITS-1:0]  r_step, n_step;
    logic [ccov_pkg::ENTRY_BITS-1:0] r_entry, n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccov_pkg::S_ACCUM;
            r_step  <= '0;
            r_entry <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_entry <= n_entry;
        end
    end

    always_comb begin
        logic [ccov_pkg::IDX_BITS-1:0] row;
        logic [ccov_pkg::IDX_BITS-1:0] col;
        row           = ccov_pkg::entry_row(r_entry);
        col           = ccov_pkg::entry_col(r_entry);
        n_state       = r_state;
        n_step        = r_step;
        n_entry       = r_entry;
        o_stall       = 1'b1;
        o_valid       = 1'b0;
        o_cmd         = '0;
        o_cmd.sel     = ccov_pkg::pair_index(row, col);
        o_cmd.row     = row;
        o_cmd.col     = col;
        o_cmd.last    = (r_entry == ccov_pkg::ENTRY_BITS'(ccov_pkg::NUM_ENTRIES - 1));
        case (r_state)
            ccov_pkg::S_ACCUM: begin
                o_stall     = 1'b0;
                o_cmd.accum = i_valid;
                if (i_valid && i_last_pixel) begin
                    n_state = ccov_pkg::S_FLUSH;
                end
            end
            ccov_pkg::S_FLUSH: begin
                n_entry = '0;
                n_state = ccov_pkg::S_LOAD;
            end
            ccov_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = ccov_pkg::S_DIV;
            end
            ccov_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == ccov_pkg::STEP_BITS'(ccov_pkg::SUM_BITS - 1)) begin
                    n_state = ccov_pkg::S_CAPT;
                end
            end
            ccov_pkg::S_CAPT: begin
                o_cmd.capture = 1'b1;
                n_state       = ccov_pkg::S_OUT;
            end
            ccov_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (o_cmd.last) begin
                        o_cmd.clear = 1'b1;
                        n_entry     = '0;
                        n_state     = ccov_pkg::S_ACCUM;
                    end else begin
                        n_entry = r_entry + 1'b1;
                        n_state = ccov_pkg::S_LOAD;
                    end
                end
            end
            default: begin
                n_state = ccov_pkg::S_ACCUM;
            end
        endcase
    end

endmodule

>>> design/ccov_datapath.sv
// Product accumulators, pixel counter, bit-serial divider and result register.
`timescale 1ns / 1ps

module ccov_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ccov_pkg::t_cmd                         i_cmd,
    input  logic [ccov_pkg::IN_BITS-1:0]           i_chan0,
    input  logic [ccov_pkg::IN_BITS-1:0]           i_chan1,
    input  logic [ccov_pkg::IN_BITS-1:0]           i_chan2,
    output logic [ccov_pkg::IDX_BITS-1:0]          o_row,
    output logic [ccov_pkg::IDX_BITS-1:0]          o_col,
    output logic signed [ccov_pkg::OUT_BITS-1:0]   o_cov_value,
    output logic                                   o_last_entry
);

    localparam int SB = ccov_pkg::SAMPLE_BITS;
    localparam int PB = ccov_pkg::PROD_BITS;
    localparam int SU = ccov_pkg::SUM_BITS;
    localparam int CB = ccov_pkg::CNT_BITS;
    localparam int OB = ccov_pkg::OUT_BITS;

    logic signed [SB-1:0] w_s0, w_s1, w_s2;
    logic signed [PB-1:0] r_prod [ccov_pkg::NUM_PAIRS];
    logic                 r_prod_en;
    logic signed [SU-1:0] r_sum [ccov_pkg::NUM_PAIRS];
    logic [CB-1:0]        r_count;
    logic                 w_full;

    logic [SU-1:0]        r_div;
    logic [CB-1:0]        r_rem;
    logic                 r_neg;
    logic signed [SU-1:0] w_sel_sum;
    logic [CB:0]          w_rem_sh;
    logic [CB+1:0]        w_diff;
    logic [OB-1:0]        w_value;

    assign w_s0   = $signed(i_chan0[SB-1:0]);
    assign w_s1   = $signed(i_chan1[SB-1:0]);
    assign w_s2   = $signed(i_chan2[SB-1:0]);
    assign w_full = r_count[ccov_pkg::MAX_PIXELS_LOG2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            r_prod[0] <= w_s0 * w_s0;
            r_prod[1] <= w_s0 * w_s1;
            r_prod[2] <= w_s0 * w_s2;
            r_prod[3] <= w_s1 * w_s1;
            r_prod[4] <= w_s1 * w_s2;
            r_prod[5] <= w_s2 * w_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_en <= 1'b0;
            r_count   <= '0;
            for (int k = 0; k < ccov_pkg::NUM_PAIRS; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            r_prod_en <= i_cmd.accum && !w_full;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.accum && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            for (int k = 0; k < ccov_pkg::NUM_PAIRS; k++) begin
                if (i_cmd.clear) begin
                    r_sum[k] <= '0;
                end else if (r_prod_en) begin
                    r_sum[k] <= r_sum[k] + {{(SU-PB){r_prod[k][PB-1]}}, r_prod[k]};
                end
            end
        end
    end

    // restoring division of the sum magnitude by the count, one quotient bit per cycle
    assign w_sel_sum = r_sum[i_cmd.sel];
    assign w_rem_sh  = {r_rem, r_div[SU-1]};
    assign w_diff    = {1'b0, w_rem_sh} - {2'b00, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= w_sel_sum[SU-1];
            r_div <= w_sel_sum[SU-1] ? SU'(-w_sel_sum) : SU'(w_sel_sum);
            r_rem <= '0;
        end else if (i_cmd.step) begin
            if (!w_diff[CB+1]) begin
                r_rem <= w_diff[CB-1:0];
                r_div <= {r_div[SU-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[CB-1:0];
                r_div <= {r_div[SU-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (!r_neg && (r_div > SU'({1'b0, {(OB-1){1'b1}}}))) begin
            w_value = {1'b0, {(OB-1){1'b1}}};
        end else if (r_neg && (r_div > SU'({1'b1, {(OB-1){1'b0}}}))) begin
            w_value = {1'b1, {(OB-1){1'b0}}};
        end else if (r_neg) begin
            w_value = -r_div[OB-1:0];
        end else begin
            w_value = r_div[OB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            o_row        <= i_cmd.row;
            o_col        <= i_cmd.col;
            o_cov_value  <= $signed(w_value);
            o_last_entry <= i_cmd.last;
        end
    end

endmodule
